### src/power_sequencing_fsm_assert.svh
// Assertion macros used by the power sequencer RTL.
`ifndef POWER_SEQUENCING_FSM_ASSERT_SVH
`define POWER_SEQUENCING_FSM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/psf_pkg.sv
// Types, codes and state-entry functions of the power sequencer.
package psf_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_UNINIT       = 9'b000000001,
    ST_STARTING     = 9'b000000010,
    ST_WAITING      = 9'b000000100,
    ST_LINKLOSS     = 9'b000001000,
    ST_CARDLOST     = 9'b000010000,
    ST_ACTIVATING   = 9'b000100000,
    ST_ACTIVE       = 9'b001000000,
    ST_DEACTIVATING = 9'b010000000,
    ST_STANDBY      = 9'b100000000
  } state_t;

  // Numeric state codes as they appear on the result channel.
  localparam logic [3:0] CODE_UNINIT       = 4'd0;
  localparam logic [3:0] CODE_STARTING     = 4'd1;
  localparam logic [3:0] CODE_WAITING      = 4'd2;
  localparam logic [3:0] CODE_LINKLOSS     = 4'd3;
  localparam logic [3:0] CODE_CARDLOST     = 4'd4;
  localparam logic [3:0] CODE_ACTIVATING   = 4'd5;
  localparam logic [3:0] CODE_ACTIVE       = 4'd6;
  localparam logic [3:0] CODE_DEACTIVATING = 4'd7;
  localparam logic [3:0] CODE_STANDBY      = 4'd8;

  // Event codes; the unused codes fall to a default arm.
  typedef enum logic [3:0] {
    EV_KICKOFF    = 4'd0,
    EV_POLL       = 4'd1,
    EV_PRESS      = 4'd2,
    EV_LINK_LOST  = 4'd3,
    EV_LINK_UP    = 4'd4,
    EV_CARD_GONE  = 4'd5,
    EV_CARD_READY = 4'd6,
    EV_AUDIO      = 4'd7,
    EV_DEINIT     = 4'd8
  } event_t;

  // LED modes.
  localparam logic [1:0] LED_OFF  = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_WAIT = 2'd2;

  // Audio unit commands.
  localparam logic [1:0] CMD_ACT_NONE     = 2'd0;
  localparam logic [1:0] CMD_ACT_PLAIN    = 2'd1;
  localparam logic [1:0] CMD_ACT_REOPEN   = 2'd2;
  localparam logic [1:0] CMD_DEACT_NONE   = 2'd0;
  localparam logic [1:0] CMD_DEACT_RAMP   = 2'd1;
  localparam logic [1:0] CMD_DEACT_NORAMP = 2'd2;

  // Audio unit states reported with each event.
  localparam logic [1:0] AU_ACTIVATED   = 2'd1;
  localparam logic [1:0] AU_DEACTIVATED = 2'd2;

  // One input item.
  typedef struct packed {
    logic [3:0] action;
    logic       sources_ready;
    logic       link_connected;
    logic       card_present;
    logic [1:0] audio_state;
  } psf_in_t;

  // One result item.
  typedef struct packed {
    logic [3:0] fsm_state;
    logic       amp_on;
    logic [1:0] led_mode;
    logic [1:0] activate_cmd;
    logic [1:0] deactivate_cmd;
    logic       powered;
    logic       is_active;
    logic       power_remembered;
  } psf_out_t;

  // Sequencer context: persistent state plus the commands of this step.
  typedef struct packed {
    state_t     mode;
    logic       reopen;
    logic       pmem;
    logic       amp;
    logic [1:0] led;
    logic [1:0] cmd_act;
    logic [1:0] cmd_deact;
  } psf_ctx_t;

  function automatic logic [3:0] state_code(state_t s);
    logic [3:0] code;
    unique case (s)
      ST_UNINIT:       code = CODE_UNINIT;
      ST_STARTING:     code = CODE_STARTING;
      ST_WAITING:      code = CODE_WAITING;
      ST_LINKLOSS:     code = CODE_LINKLOSS;
      ST_CARDLOST:     code = CODE_CARDLOST;
      ST_ACTIVATING:   code = CODE_ACTIVATING;
      ST_ACTIVE:       code = CODE_ACTIVE;
      ST_DEACTIVATING: code = CODE_DEACTIVATING;
      ST_STANDBY:      code = CODE_STANDBY;
      default:         code = CODE_UNINIT;
    endcase
    return code;
  endfunction

  function automatic psf_ctx_t go_standby(psf_ctx_t c);
    psf_ctx_t r;
    r      = c;
    r.amp  = 1'b0;
    r.led  = LED_OFF;
    r.mode = ST_STANDBY;
    return r;
  endfunction

  // Power up the amplifier and ask the audio unit to start.
  function automatic psf_ctx_t go_activating(psf_ctx_t c, logic [1:0] au);
    psf_ctx_t r;
    r         = c;
    r.amp     = 1'b1;
    r.led     = LED_ON;
    r.pmem    = 1'b1;
    r.cmd_act = c.reopen ? CMD_ACT_REOPEN : CMD_ACT_PLAIN;
    r.reopen  = 1'b0;
    r.mode    = (au == AU_ACTIVATED) ? ST_ACTIVE : ST_ACTIVATING;
    return r;
  endfunction

  function automatic psf_ctx_t go_waiting(psf_ctx_t c, logic lnk, logic card,
                                          logic [1:0] au);
    psf_ctx_t r;
    r      = c;
    r.mode = ST_WAITING;
    r.led  = LED_WAIT;
    if (lnk && card) begin
      r = go_activating(r, au);
    end
    return r;
  endfunction

  function automatic psf_ctx_t go_deactivating(psf_ctx_t c, logic [1:0] au);
    psf_ctx_t r;
    r           = c;
    r.pmem      = 1'b0;
    r.cmd_deact = CMD_DEACT_RAMP;
    r.mode      = ST_DEACTIVATING;
    if (au == AU_DEACTIVATED) begin
      r = go_standby(r);
    end
    return r;
  endfunction

  // Shut the audio down after a lost link or card, then wait if already down.
  function automatic psf_ctx_t go_loss(psf_ctx_t c, logic [1:0] kind, state_t st,
                                       logic lnk, logic card, logic [1:0] au);
    psf_ctx_t r;
    r           = c;
    r.cmd_deact = kind;
    r.mode      = st;
    if (au == AU_DEACTIVATED) begin
      r = go_waiting(r, lnk, card, au);
    end
    return r;
  endfunction

  function automatic psf_ctx_t startup_done(psf_ctx_t c, logic lnk, logic card,
                                            logic [1:0] au);
    psf_ctx_t r;
    if (lnk) begin
      r = c.pmem ? go_activating(c, au) : go_standby(c);
    end else begin
      r = go_waiting(c, lnk, card, au);
    end
    return r;
  endfunction

endpackage

### src/psf_step.sv
// Transition logic of the power sequencer: one event in, next context and result out.
module psf_step
  import psf_pkg::*;
(
  input  psf_ctx_t cur,
  input  psf_in_t  item,
  output psf_ctx_t nxt,
  output psf_out_t res
);

  psf_ctx_t c;
  psf_ctx_t n;
  event_t   ev;
  logic     srcs;
  logic     lnk;
  logic     card;
  logic [1:0] au;

  assign ev   = event_t'(item.action);
  assign srcs = item.sources_ready;
  assign lnk  = item.link_connected;
  assign card = item.card_present;
  assign au   = item.audio_state;

  // Dispatch the event and run any chain of state entries it triggers.
  always_comb begin
    c           = cur;
    c.cmd_act   = CMD_ACT_NONE;
    c.cmd_deact = CMD_DEACT_NONE;
    n           = c;
    unique case (ev) inside
      EV_KICKOFF: begin
        n.mode = ST_STARTING;
        if (srcs) begin
          n = startup_done(n, lnk, card, au);
        end
      end
      EV_POLL: begin
        if (c.mode == ST_STARTING && srcs) begin
          n = startup_done(c, lnk, card, au);
        end
      end
      EV_PRESS: begin
        if (c.mode == ST_STANDBY) begin
          n = go_waiting(c, lnk, card, au);
        end else if (c.mode == ST_WAITING) begin
          n = go_standby(c);
        end else if (c.mode == ST_LINKLOSS || c.mode == ST_CARDLOST) begin
          n.mode = ST_DEACTIVATING;
        end else if (c.mode == ST_ACTIVATING || c.mode == ST_ACTIVE) begin
          n = go_deactivating(c, au);
        end
      end
      EV_LINK_LOST: begin
        if (c.mode != ST_STANDBY) begin
          n = go_loss(c, CMD_DEACT_RAMP, ST_LINKLOSS, lnk, card, au);
        end
      end
      EV_LINK_UP, EV_CARD_READY: begin
        if (c.mode == ST_WAITING && lnk && card) begin
          n = go_activating(c, au);
        end
      end
      EV_CARD_GONE: begin
        n.reopen = 1'b1;
        if (c.mode != ST_STANDBY) begin
          n = go_loss(n, CMD_DEACT_NORAMP, ST_CARDLOST, lnk, card, au);
        end
      end
      EV_AUDIO: begin
        if (c.mode == ST_ACTIVATING && au == AU_ACTIVATED) begin
          n.mode = ST_ACTIVE;
        end else if (c.mode == ST_DEACTIVATING && au == AU_DEACTIVATED) begin
          n = go_standby(c);
        end else if ((c.mode == ST_LINKLOSS || c.mode == ST_CARDLOST) &&
                     au == AU_DEACTIVATED) begin
          n = go_waiting(c, lnk, card, au);
        end
      end
      EV_DEINIT: begin
        n.mode = ST_UNINIT;
      end
      default: begin
        n = c;
      end
    endcase
  end

  assign nxt = n;

  // Result fields follow the context after the step.
  always_comb begin
    res.fsm_state        = state_code(n.mode);
    res.amp_on           = n.amp;
    res.led_mode         = n.led;
    res.activate_cmd     = n.cmd_act;
    res.deactivate_cmd   = n.cmd_deact;
    res.powered          = (n.mode != ST_STANDBY) && (n.mode != ST_DEACTIVATING);
    res.is_active        = (n.mode == ST_ACTIVE);
    res.power_remembered = n.pmem;
  end

endmodule

### src/power_sequencing_fsm.sv
// Power sequencer top level: input stage, sequencer state and result register.
//
// Events enter on the in_ channel (in_valid/in_ready, payload in_data) and
// each one produces exactly one result on the out_ channel (out_valid/
// out_ready, payload out_data) carrying the new state, amplifier and LED
// levels and any activate or deactivate command issued for that event.
// A transfer lands in the input register; the transition logic then runs
// through the whole entry chain and the result register loads once the
// result slot is free, so out_valid rises and the result can transfer to
// the receiver. The block takes one event per cycle while out_ready stays
// high, set by the single pass through the transition logic between the
// input and result registers.
// cfg_we with cfg_wdata loads the remembered power-on flag; write it only
// while no event is in flight.
// Reset (rst_n low, synchronous) empties both registers and puts the
// sequencer in the uninitialized state with the reopen flag set and the
// remembered power-on flag cleared.
// When the receiver holds out_ready low the result waits in its register;
// one more event can still enter the input register and then in_ready drops.
module power_sequencing_fsm
  import psf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  psf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output psf_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

`include "power_sequencing_fsm_assert.svh"

  logic     in_valid_r;
  psf_in_t  in_item_r;
  logic     out_valid_r;
  psf_out_t out_item_r;
  state_t   state_r;
  logic     reopen_r;
  logic     pmem_r;
  logic     amp_r;
  logic [1:0] led_r;

  logic     out_free;
  logic     adv;
  psf_ctx_t cur_ctx;
  psf_ctx_t step_nxt;
  psf_out_t step_res;

  // Handshake: the step fires when an event waits and the result slot frees.
  assign out_free = !out_valid_r || out_ready;
  assign adv      = in_valid_r && out_free;
  assign in_ready = !in_valid_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // Current sequencer context.
  always_comb begin
    cur_ctx.mode      = state_r;
    cur_ctx.reopen    = reopen_r;
    cur_ctx.pmem      = pmem_r;
    cur_ctx.amp       = amp_r;
    cur_ctx.led       = led_r;
    cur_ctx.cmd_act   = CMD_ACT_NONE;
    cur_ctx.cmd_deact = CMD_DEACT_NONE;
  end

  psf_step u_step (
    .cur  (cur_ctx),
    .item (in_item_r),
    .nxt  (step_nxt),
    .res  (step_res)
  );

  // Sequencer state; a configuration write reloads the power memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_UNINIT;
      reopen_r <= 1'b1;
      pmem_r   <= 1'b0;
      amp_r    <= 1'b0;
      led_r    <= LED_OFF;
    end else begin
      if (adv) begin
        state_r  <= step_nxt.mode;
        reopen_r <= step_nxt.reopen;
        amp_r    <= step_nxt.amp;
        led_r    <= step_nxt.led;
      end
      if (cfg_we) begin
        pmem_r <= cfg_wdata;
      end else if (adv) begin
        pmem_r <= step_nxt.pmem;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Checks on the pipeline control and the sequencer state.
  `PSF_ASSERT_NEXT(a_step_gives_result, adv, out_valid_r, "step did not load a result")
  `PSF_ASSERT_NEXT(a_held_event_kept, in_valid_r && !adv,
                   in_valid_r && $stable(in_item_r), "waiting event was lost")
  `PSF_ASSERT_NEXT(a_state_only_on_step, !adv,
                   $stable(state_r) && $stable(reopen_r), "state moved without a step")
  `PSF_ASSERT_NEXT(a_activate_sets_flags, adv && !cfg_we && step_res.activate_cmd != CMD_ACT_NONE,
                   amp_r && pmem_r && !reopen_r, "activation left flags wrong")
  `PSF_ASSERT_NOW(a_ready_when_empty, !in_ready, in_valid_r, "input stage stalled while empty")

endmodule
